// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key/value cache: item structs, operation codes, constants.
// No dependencies; used by every module of the block.
package lkvc_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [CAP_W-1:0]        CAP_RESET  = 5'd16;
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
	localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

	typedef struct packed {
		logic                      operation;
		logic signed [DATA_W-1:0]  key;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic                      found;
		logic signed [DATA_W-1:0]  read_value;
		logic                      evicted;
	} rsp_t;

endpackage

// ===== rtl/lkvc_store.sv =====
// Entry store of the LRU cache: key CAM, values, valid bits, recency ranks, occupancy.
// Computes the result of the staged item and updates the state at the same edge.
// Depends on lkvc_pkg.
module lkvc_store #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  lkvc_pkg::req_t            item,
	input  logic [lkvc_pkg::CAP_W-1:0] capacity,
	output lkvc_pkg::rsp_t            result
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;

	logic signed [lkvc_pkg::DATA_W-1:0] key_q   [MAX_ENTRIES];
	logic signed [lkvc_pkg::DATA_W-1:0] value_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]             valid_q;
	logic [IW-1:0]                      rank_q  [MAX_ENTRIES];
	logic [OW-1:0]                      occ_q;

	logic [MAX_ENTRIES-1:0]             hit_vec, lru_vec, touch_vec;
	logic                               hit, has_free, full, do_evict, do_insert;
	logic [IW-1:0]                      hit_idx, lru_idx, free_idx, wr_idx, touch_r;
	logic [IW-1:0]                      hit_rank, lru_rank;
	logic signed [lkvc_pkg::DATA_W-1:0] hit_value;
	logic [CW-1:0]                      cap_ext, max_ext, eff_cap;
	logic                               wr_key, wr_val;
	logic [IW-1:0]                      rank_d  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]             valid_d;
	logic [OW-1:0]                      occ_d;

	always_comb begin
		lru_rank  = IW'(occ_q - OW'(1));
		hit_idx   = '0;
		lru_idx   = '0;
		hit_rank  = '0;
		hit_value = '0;
		free_idx  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == item.key);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
			if (hit_vec[i]) begin
				hit_idx   = hit_idx | IW'(i);
				hit_rank  = hit_rank | rank_q[i];
				hit_value = hit_value | value_q[i];
			end
			if (lru_vec[i])
				lru_idx = lru_idx | IW'(i);
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i])
				free_idx = IW'(i);
		end
		hit      = |hit_vec;
		has_free = ~&valid_q;
	end

	// effective capacity: zero means one, clamp to the entry count
	always_comb begin
		cap_ext = CW'(capacity);
		max_ext = CW'(MAX_ENTRIES);
		if (capacity == '0)
			eff_cap = CW'(1);
		else if (cap_ext > max_ext)
			eff_cap = max_ext;
		else
			eff_cap = cap_ext;
		full = (CW'(occ_q) >= eff_cap) || !has_free;
	end

	always_comb begin
		do_evict  = (item.operation == lkvc_pkg::OP_PUT) && !hit && full && (occ_q != '0);
		do_insert = (item.operation == lkvc_pkg::OP_PUT) && !hit && !do_evict;
		wr_key    = do_evict || do_insert;
		wr_val    = wr_key || (hit && (item.operation == lkvc_pkg::OP_PUT));
		if (hit)
			wr_idx = hit_idx;
		else if (do_evict)
			wr_idx = lru_idx;
		else
			wr_idx = free_idx;

		touch_vec = hit ? hit_vec : (do_evict ? lru_vec : '0);
		touch_r   = hit ? hit_rank : lru_rank;

		valid_d = valid_q;
		occ_d   = occ_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (do_insert) begin
				if (valid_q[i])
					rank_d[i] = rank_q[i] + IW'(1);
			end else if (touch_vec[i]) begin
				rank_d[i] = '0;
			end else if ((hit || do_evict) && valid_q[i] && (rank_q[i] < touch_r)) begin
				rank_d[i] = rank_q[i] + IW'(1);
			end
		end
		if (do_insert) begin
			valid_d[free_idx] = 1'b1;
			rank_d[free_idx]  = '0;
			occ_d             = occ_q + OW'(1);
		end
	end

	always_comb begin
		result.found   = hit;
		result.evicted = do_evict;
		if (item.operation == lkvc_pkg::OP_PUT)
			result.read_value = lkvc_pkg::PUT_VALUE;
		else if (hit)
			result.read_value = hit_value;
		else
			result.read_value = lkvc_pkg::MISS_VALUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++)
				rank_q[i] <= '0;
		end else if (upd) begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < MAX_ENTRIES; i++)
				rank_q[i] <= rank_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (upd && wr_key)
			key_q[wr_idx] <= item.key;
		if (upd && wr_val)
			value_q[wr_idx] <= item.value;
	end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key/value cache.
// Input stage, capacity register and result register; instantiates lkvc_store.
// Depends on lkvc_pkg and lkvc_store.
//
//   channel   handshake                  payload
//   request   req_valid / req_ready      req (operation, key, value)
//   response  rsp_valid / rsp_ready      rsp (found, read_value, evicted)
//   config    cfg_we                     cfg_wdata (capacity)
//
// One item per cycle sustained while rsp_ready is high; after a request is accepted,
// its response passes through the input stage, then the result register.
// Lookup, recency update and write all happen in the same cycle from the input stage.
// Reset empties the store and sets capacity to 16.
// A held response stalls an occupied input stage, which then drops req_ready.
module lru_key_value_cache_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  lkvc_pkg::req_t            req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output lkvc_pkg::rsp_t            rsp,
	input  logic                      cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

	logic                       valid_s1, valid_s2, adv_s1;
	lkvc_pkg::req_t             item_s1;
	lkvc_pkg::rsp_t             rsp_s2, result;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= lkvc_pkg::CAP_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (rsp_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			item_s1 <= req;
		if (adv_s1)
			rsp_s2 <= result;
	end

	lkvc_store #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv_s1),
		.item     (item_s1),
		.capacity (cap_q),
		.result   (result)
	);

endmodule

// ===== rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg.
module lkvc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input lkvc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lkvc_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> !rsp.found && (rsp.read_value == lkvc_pkg::PUT_VALUE))
		else $error("eviction reported on a hit or a get");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |->
			(rsp.read_value == lkvc_pkg::MISS_VALUE) || (rsp.read_value == lkvc_pkg::PUT_VALUE))
		else $error("miss returned a stored value");

	// a quiet cycle with no accepted item, then another, leaves nothing in flight
	a_no_rsp_without_req: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && !(req_valid && req_ready) ##1 !rsp_valid && !(req_valid && req_ready)
		|=> !rsp_valid)
		else $error("response without a request");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
